[design/vtc_pkg.sv]
package vtc_pkg;

    // operation codes
    localparam logic [1:0] FUNC_CLASSIFY = 2'd0;
    localparam logic [1:0] FUNC_INSERT   = 2'd1;
    localparam logic [1:0] FUNC_REMOVE   = 2'd2;
    localparam logic [1:0] FUNC_NOP      = 2'd3;

    // result status codes
    localparam logic [2:0] ST_PASSED    = 3'd0;
    localparam logic [2:0] ST_DELIVERED = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_INSERTED  = 3'd3;
    localparam logic [2:0] ST_IN_USE    = 3'd4;
    localparam logic [2:0] ST_BUSY      = 3'd5;
    localparam logic [2:0] ST_REMOVED   = 3'd6;
    localparam logic [2:0] ST_ABSENT    = 3'd7;

    // tag protocol identifiers
    localparam logic [15:0] TPID_CUSTOMER = 16'h8100;
    localparam logic [15:0] TPID_SERVICE  = 16'h88a8;

    // slot field reaches at most this many table rows
    localparam int SLOT_SPAN = 32;

    // input beat
    typedef struct packed {
        logic [1:0]  func;
        logic        hw_tagged;
        logic [15:0] outer_etype;
        logic [15:0] tag_control;
        logic [7:0]  parent_index;
        logic [4:0]  slot;
        logic        entry_kind;
        logic [11:0] entry_vlan_id;
    } t_in;

    // result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot_out;
        logic [11:0] vlan_id;
        logic [2:0]  priority_res;
        logic        strip_header;
    } t_out;

    // one table row, also the lookup key
    typedef struct packed {
        logic [7:0]  parent;
        logic        kind;
        logic [11:0] vid;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic cmp_en;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic out_free;
    } t_sts;

endpackage

[design/vtc_ctrl.sv]
module vtc_ctrl
    import vtc_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_func,
    output logic          o_in_stall,
    input  t_sts          i_sts,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_rd_addr
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_issued, n_issued;
    logic          r_pend, n_pend;
    logic          r_pend_last, n_pend_last;

    assign o_in_stall = (r_state != S_IDLE);
    assign o_rd_addr  = r_cnt;

    // sequencer: accept, sweep the table one row a cycle (classify, insert), then post result
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_issued    = r_issued;
        n_pend      = 1'b0;
        n_pend_last = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_func)
                        FUNC_CLASSIFY, FUNC_INSERT: begin
                            n_state  = S_SCAN;
                            n_cnt    = '0;
                            n_issued = 1'b0;
                        end
                        FUNC_REMOVE: begin
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.rd_en  = !r_issued;
                o_cmd.cmp_en = r_pend;
                if (!r_issued) begin
                    n_pend      = 1'b1;
                    n_pend_last = (r_cnt == LAST);
                    if (r_cnt == LAST) begin
                        n_issued = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                // first hit wins, else stop after the last row compares
                if (r_pend && (i_sts.hit || r_pend_last)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_issued    <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_issued    <= n_issued;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
        end
    end

`ifndef SYNTHESIS
    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("result posted while output register full");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pend && r_pend_last) |=> (r_state == S_DONE))
        else $error("scan ran past last row");

    a_load_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_func != FUNC_NOP) |=> (r_state != S_IDLE))
        else $error("accepted beat was not processed");

    a_cmp_only_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cmp_en |-> $past(o_cmd.rd_en))
        else $error("compare without a preceding read");
`endif

endmodule

[design/vtc_dp.sv]
module vtc_dp
    import vtc_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_in           i_in,
    input  t_cmd          i_cmd,
    input  logic [AW-1:0] i_rd_addr,
    output t_sts          o_sts,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output t_out          o_out
);

    t_in           r_item;
    t_entry        r_key;
    t_entry        r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_entry        r_rd_ent;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic          r_found;
    logic [AW-1:0] r_found_idx;
    logic          r_out_valid;
    t_out          r_out;

    logic          hit;
    logic          in_range;
    logic [AW-1:0] slot_idx;
    logic          slot_used;
    logic          tag_present;
    logic [2:0]    pri_raw;
    logic [2:0]    pri_swap;
    logic          wr_en;
    logic          clr_en;
    t_out          res;
    t_entry        load_key;

    // lookup key for the incoming beat
    always_comb begin
        load_key.parent = i_in.parent_index;
        if (i_in.func == FUNC_CLASSIFY) begin
            load_key.kind = !i_in.hw_tagged && (i_in.outer_etype == TPID_SERVICE);
            load_key.vid  = i_in.tag_control[11:0];
        end else begin
            load_key.kind = i_in.entry_kind;
            load_key.vid  = i_in.entry_vlan_id;
        end
    end

    // capture beat and key
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
            r_key  <= load_key;
        end
    end

    // table storage and registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[slot_idx] <= r_key;
        end
        if (i_cmd.rd_en) begin
            r_rd_ent <= r_mem[i_rd_addr];
            r_rd_vld <= r_valid[i_rd_addr];
            r_rd_idx <= i_rd_addr;
        end
    end

    // row compare
    assign hit = r_rd_vld && (r_rd_ent == r_key);

    // first match latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_found <= 1'b0;
        end else if (i_cmd.cmp_en && hit && !r_found) begin
            r_found     <= 1'b1;
            r_found_idx <= r_rd_idx;
        end
    end

    // slot checks
    assign in_range  = (32'(r_item.slot) < DEPTH);
    assign slot_idx  = r_item.slot[AW-1:0];
    assign slot_used = in_range && r_valid[slot_idx];

    // tag decode and priority remap
    assign tag_present = r_item.hw_tagged || (r_item.outer_etype == TPID_CUSTOMER)
                         || (r_item.outer_etype == TPID_SERVICE);
    assign pri_raw  = r_item.tag_control[15:13];
    assign pri_swap = {pri_raw[2:1], pri_raw[0] ^ (pri_raw[2:1] == 2'd0)};

    // result and table update
    always_comb begin
        res    = '0;
        wr_en  = 1'b0;
        clr_en = 1'b0;
        case (r_item.func)
            FUNC_CLASSIFY: begin
                if (tag_present) begin
                    res.vlan_id      = r_item.tag_control[11:0];
                    res.priority_res = pri_swap;
                    if (r_found) begin
                        res.status       = ST_DELIVERED;
                        res.slot_out     = 5'(r_found_idx);
                        res.strip_header = !r_item.hw_tagged;
                    end else begin
                        res.status = ST_DROPPED;
                    end
                end else begin
                    res.status = ST_PASSED;
                end
            end
            FUNC_INSERT: begin
                res.slot_out = r_item.slot;
                res.vlan_id  = r_item.entry_vlan_id;
                if (!in_range || slot_used) begin
                    res.status = ST_BUSY;
                end else if (r_found) begin
                    res.status = ST_IN_USE;
                end else begin
                    res.status = ST_INSERTED;
                    wr_en      = i_cmd.finish;
                end
            end
            FUNC_REMOVE: begin
                res.slot_out = r_item.slot;
                if (slot_used) begin
                    res.status = ST_REMOVED;
                    clr_en     = i_cmd.finish;
                end else begin
                    res.status = ST_ABSENT;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[slot_idx] <= 1'b1;
        end else if (clr_en) begin
            r_valid[slot_idx] <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= res;
        end
    end

    assign o_sts.hit      = hit;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;

`ifndef SYNTHESIS
    a_insert_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_valid[$past(slot_idx)])
        else $error("inserted row not marked valid");

    a_remove_clears_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_en |=> !r_valid[$past(slot_idx)])
        else $error("removed row still valid");

    a_delivered_row_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && res.status == ST_DELIVERED) |-> r_valid[r_found_idx])
        else $error("delivery to an empty row");
`endif

endmodule

[design/vlan_tag_classifier_table.sv]
// VLAN tag classifier: each input beat classifies a frame header, inserts a
// table row or removes one, and yields one result beat (func code 3 is
// consumed with no result). Classify and insert sweep the table one row per
// cycle through a single registered read port, stopping at the first hit;
// remove skips the sweep. A result that cannot enter a full output register
// waits until there is room. The finished result sits in an output register,
// so the next beat is taken while it waits. The table is empty after reset
// with no clearing pass.
module vlan_tag_classifier_table
    import vtc_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int DEPTH = (ENTRIES < SLOT_SPAN) ? ENTRIES : SLOT_SPAN;
    localparam int AW    = $clog2(DEPTH);

    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] rd_addr;

    // sequencer
    vtc_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in.func),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr)
    );

    // table and result path
    vtc_dp #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

[dv/vtc_checker.sv]
module vtc_checker
    import vtc_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out,
    output int   o_errors,
    output int   o_pending
);

    // tag kinds as held in a table row
    localparam logic KIND_CUSTOMER = 1'b0;
    localparam logic KIND_SERVICE  = 1'b1;

    // shadow of the classifier table
    bit     row_valid [ENTRIES];
    t_entry row_key   [ENTRIES];

    // results owed by the block, oldest first
    t_out   owed_results [$];
    int     mismatch_count = 0;

    // lowest valid row holding this key, or -1
    function automatic int find_row(input t_entry key);
        for (int i = 0; i < ENTRIES; i++) begin
            if (row_valid[i] && row_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // work out the result of one input beat and update the shadow table
    task automatic classify_or_edit(input t_in beat);
        t_out   res;
        t_entry key;
        int     hit;
        logic   tag_present;
        res         = '0;
        tag_present = 1'b1;
        case (beat.func)
            FUNC_CLASSIFY: begin
                key.parent = beat.parent_index;
                key.vid    = beat.tag_control[11:0];
                key.kind   = KIND_CUSTOMER;
                // an out-of-band tag always counts as customer
                if (!beat.hw_tagged) begin
                    if (beat.outer_etype == TPID_SERVICE) begin
                        key.kind = KIND_SERVICE;
                    end else if (beat.outer_etype != TPID_CUSTOMER) begin
                        tag_present = 1'b0;
                    end
                end
                if (!tag_present) begin
                    res.status = ST_PASSED;
                end else begin
                    res.vlan_id      = key.vid;
                    res.priority_res = beat.tag_control[15:13];
                    // 802.1p priorities 0 and 1 trade places
                    if (res.priority_res <= 3'd1) begin
                        res.priority_res[0] = ~res.priority_res[0];
                    end
                    hit = find_row(key);
                    if (hit < 0) begin
                        res.status = ST_DROPPED;
                    end else begin
                        res.status       = ST_DELIVERED;
                        res.slot_out     = hit[4:0];
                        res.strip_header = ~beat.hw_tagged;
                    end
                end
                owed_results.push_back(res);
            end
            FUNC_INSERT: begin
                key.parent   = beat.parent_index;
                key.kind     = beat.entry_kind;
                key.vid      = beat.entry_vlan_id;
                res.slot_out = beat.slot;
                res.vlan_id  = beat.entry_vlan_id;
                // occupied slot is refused before the duplicate check
                if (int'(beat.slot) >= ENTRIES || row_valid[beat.slot]) begin
                    res.status = ST_BUSY;
                end else if (find_row(key) >= 0) begin
                    res.status = ST_IN_USE;
                end else begin
                    row_valid[beat.slot] = 1'b1;
                    row_key[beat.slot]   = key;
                    res.status           = ST_INSERTED;
                end
                owed_results.push_back(res);
            end
            FUNC_REMOVE: begin
                res.slot_out = beat.slot;
                if (int'(beat.slot) < ENTRIES && row_valid[beat.slot]) begin
                    row_valid[beat.slot] = 1'b0;
                    res.status           = ST_REMOVED;
                end else begin
                    res.status = ST_ABSENT;
                end
                owed_results.push_back(res);
            end
            default: begin
                // unused code: consumed silently
            end
        endcase
    endtask

    task automatic report_field(input string name, input logic [11:0] want,
                                input logic [11:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // compare one result beat against the oldest owed result
    task automatic check_result(input t_out got);
        t_out want;
        if (owed_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result beat with nothing expected, actual %h", $time, got);
        end else begin
            want = owed_results.pop_front();
            report_field("status", 12'(want.status), 12'(got.status));
            report_field("slot_out", 12'(want.slot_out), 12'(got.slot_out));
            report_field("vlan_id", want.vlan_id, got.vlan_id);
            report_field("priority_res", 12'(want.priority_res), 12'(got.priority_res));
            report_field("strip_header", 12'(want.strip_header), 12'(got.strip_header));
        end
    endtask

    // watch both channels; results come from earlier beats, so check them first
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                row_valid[i] = 1'b0;
            end
            owed_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out);
            end
            if (i_in_valid && !i_in_stall) begin
                classify_or_edit(i_in);
            end
        end
        o_pending <= owed_results.size();
        o_errors  <= mismatch_count;
    end

endmodule

[dv/tb.sv]
module tb;
    import vtc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 40;
    localparam int PHASE_BEATS    = 483;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_beat   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_beat;
    int   hold_asked  = 0;
    int   hold_served = 0;

    int   src_idle_pct = 0;
    int   rx_idle_pct  = 0;
    int   fail_count;
    int   owed_count;
    int   quiet_cycles;

    vlan_tag_classifier_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    vtc_checker u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_beat),
        .o_errors    (fail_count),
        .o_pending   (owed_count)
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_in make_beat(input logic [1:0] func, input logic hw,
                                      input logic [15:0] etype, input logic [15:0] tci,
                                      input logic [7:0] parent, input logic [4:0] slot,
                                      input logic kind, input logic [11:0] evid);
        t_in b;
        b.func          = func;
        b.hw_tagged     = hw;
        b.outer_etype   = etype;
        b.tag_control   = tci;
        b.parent_index  = parent;
        b.slot          = slot;
        b.entry_kind    = kind;
        b.entry_vlan_id = evid;
        return b;
    endfunction

    // keys mostly from a small pool so that lookups hit
    function automatic logic [7:0] pick_parent();
        case ($urandom_range(9))
            0: return 8'($urandom_range(255));
            1: return 8'hff;
            default: return 8'($urandom_range(3));
        endcase
    endfunction

    function automatic logic [11:0] pick_vid();
        case ($urandom_range(9))
            0: return 12'($urandom_range(4095));
            1: return 12'hfff;
            default: return 12'($urandom_range(7));
        endcase
    endfunction

    // random beat: mostly tagged frames and table edits, some noise
    function automatic t_in random_beat();
        t_in b;
        int  pick;
        b = make_beat(FUNC_CLASSIFY, 1'($urandom_range(1)), 16'($urandom_range(16'hffff)),
                      16'($urandom_range(16'hffff)), 8'($urandom_range(255)),
                      5'($urandom_range(31)), 1'($urandom_range(1)),
                      12'($urandom_range(4095)));
        pick = $urandom_range(99);
        if (pick < 45) begin
            b.hw_tagged = ($urandom_range(4) == 0);
            case ($urandom_range(9))
                0, 1, 2, 3: b.outer_etype = TPID_CUSTOMER;
                4, 5, 6:    b.outer_etype = TPID_SERVICE;
                default:    b.outer_etype = 16'($urandom_range(16'hffff));
            endcase
            b.tag_control  = {4'($urandom_range(15)), pick_vid()};
            b.parent_index = pick_parent();
        end else if (pick < 72) begin
            b.func          = FUNC_INSERT;
            b.parent_index  = pick_parent();
            b.entry_vlan_id = pick_vid();
        end else if (pick < 95) begin
            b.func = FUNC_REMOVE;
        end else begin
            b.func = FUNC_NOP;
        end
        return b;
    endfunction

    // offer one beat, hold it until taken, then maybe go quiet a while
    task automatic send_beat(input t_in b);
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        if ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            do begin
                @(posedge clk);
            end while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    // stop offering until every owed result has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (owed_count != 0);
    endtask

    // receiver: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_asked != hold_served) begin
                hold_served = hold_served + 1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // watchdog on cycles with no beat moving on either channel
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus and verdict
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 33;
        rx_idle_pct  = 58;

        // untagged, near-miss ethertype, empty-table lookups with priority swap
        send_beat(make_beat(FUNC_CLASSIFY, 1'b0, 16'h0800, 16'hffff, 8'h00, 5'd0, 1'b0, 12'h0));
        send_beat(make_beat(FUNC_CLASSIFY, 1'b0, 16'h88a9, 16'h2001, 8'h01, 5'd0, 1'b0, 12'h0));
        send_beat(make_beat(FUNC_CLASSIFY, 1'b0, TPID_CUSTOMER, 16'h0000, 8'h00, 5'd0, 1'b0,
                            12'h0));
        send_beat(make_beat(FUNC_CLASSIFY, 1'b0, TPID_SERVICE, 16'h2fff, 8'hff, 5'd0, 1'b0,
                            12'h0));
        send_beat(make_beat(FUNC_CLASSIFY, 1'b1, 16'hffff, 16'hffff, 8'hff, 5'd31, 1'b1,
                            12'hfff));
        // inserts: fresh, extremes, busy slot, duplicate, same key other kind
        send_beat(make_beat(FUNC_INSERT, 1'b0, 16'h0, 16'h0, 8'h00, 5'd0, 1'b0, 12'h000));
        send_beat(make_beat(FUNC_INSERT, 1'b1, 16'hffff, 16'hffff, 8'hff, 5'd31, 1'b1,
                            12'hfff));
        send_beat(make_beat(FUNC_INSERT, 1'b0, 16'h0, 16'h0, 8'h07, 5'd0, 1'b1, 12'h123));
        send_beat(make_beat(FUNC_INSERT, 1'b0, 16'h0, 16'h0, 8'h00, 5'd5, 1'b0, 12'h000));
        send_beat(make_beat(FUNC_INSERT, 1'b0, 16'h0, 16'h0, 8'h00, 5'd6, 1'b1, 12'h000));
        // deliveries: out-of-band, in-frame customer and service, hw overrides ethertype
        send_beat(make_beat(FUNC_CLASSIFY, 1'b1, 16'h0800, 16'h4000, 8'h00, 5'd0, 1'b0,
                            12'h0));
        send_beat(make_beat(FUNC_CLASSIFY, 1'b0, TPID_CUSTOMER, 16'h3000, 8'h00, 5'd0, 1'b0,
                            12'h0));
        send_beat(make_beat(FUNC_CLASSIFY, 1'b0, TPID_SERVICE, 16'h1000, 8'h00, 5'd0, 1'b0,
                            12'h0));
        send_beat(make_beat(FUNC_CLASSIFY, 1'b1, TPID_SERVICE, 16'h0000, 8'h00, 5'd0, 1'b0,
                            12'h0));
        send_beat(make_beat(FUNC_CLASSIFY, 1'b0, TPID_SERVICE, 16'hefff, 8'hff, 5'd0, 1'b0,
                            12'h0));
        // kind and parent mismatches drop
        send_beat(make_beat(FUNC_CLASSIFY, 1'b0, TPID_CUSTOMER, 16'h0fff, 8'hff, 5'd0, 1'b0,
                            12'h0));
        send_beat(make_beat(FUNC_CLASSIFY, 1'b0, TPID_SERVICE, 16'h0fff, 8'hfe, 5'd0, 1'b0,
                            12'h0));
        // unused code
        send_beat(make_beat(FUNC_NOP, 1'b1, 16'hffff, 16'hffff, 8'hff, 5'd31, 1'b1, 12'hfff));
        // removes, empty slot, lookup after removal, key reuse
        send_beat(make_beat(FUNC_REMOVE, 1'b0, 16'h0, 16'h0, 8'h00, 5'd0, 1'b0, 12'h0));
        send_beat(make_beat(FUNC_REMOVE, 1'b0, 16'h0, 16'h0, 8'h00, 5'd0, 1'b0, 12'h0));
        send_beat(make_beat(FUNC_CLASSIFY, 1'b0, TPID_CUSTOMER, 16'h0000, 8'h00, 5'd0, 1'b0,
                            12'h0));
        send_beat(make_beat(FUNC_REMOVE, 1'b0, 16'h0, 16'h0, 8'h00, 5'd31, 1'b0, 12'h0));
        send_beat(make_beat(FUNC_REMOVE, 1'b0, 16'h0, 16'h0, 8'h00, 5'd6, 1'b0, 12'h0));
        send_beat(make_beat(FUNC_INSERT, 1'b0, 16'h0, 16'h0, 8'h00, 5'd5, 1'b0, 12'h000));
        wait_for_drain();

        // random traffic in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 33;
                    rx_idle_pct  = 58;
                end
                1: begin
                    src_idle_pct = 58;
                    rx_idle_pct  = 33;
                end
                default: begin
                    src_idle_pct = 0;
                    rx_idle_pct  = 0;
                end
            endcase
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // receiver holds off while beats keep coming, so the block backs up
                if (n == 120) begin
                    hold_asked <= hold_asked + 1;
                end
                if (n == 300) begin
                    wait_for_drain();
                end
                send_beat(random_beat());
            end
            wait_for_drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && owed_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
design/vtc_pkg.sv
design/vtc_ctrl.sv
design/vtc_dp.sv
design/vlan_tag_classifier_table.sv
dv/vtc_checker.sv
dv/tb.sv
